[rtl/lmts_pkg.sv]
// ----------------------------------------------------------------------------
// LCD mode timing sequencer package
// Shared types, register codes, mode codes and reset values used by the
// sequencer's modules.
// ----------------------------------------------------------------------------
package lmts_pkg;

   // Operation codes carried by an input item.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Register selects for bus accesses.
   localparam logic [1:0] SEL_CONTROL = 2'd0;
   localparam logic [1:0] SEL_STATUS  = 2'd1;
   localparam logic [1:0] SEL_LINE    = 2'd2;
   localparam logic [1:0] SEL_COMPARE = 2'd3;

   // Display mode codes as kept in status bits 1..0.
   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   // Status and control bit positions.
   localparam int unsigned CTRL_ENABLE_BIT  = 7;
   localparam int unsigned STAT_MATCH_BIT   = 2;
   localparam int unsigned STAT_HBLANK_IE   = 3;
   localparam int unsigned STAT_VBLANK_IE   = 4;
   localparam int unsigned STAT_OAM_IE      = 5;
   localparam int unsigned STAT_MATCH_IE    = 6;

   // Timing register indexes on the configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OAM_TICKS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_XFER_TICKS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HBLANK_TICKS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VBLANK_TICKS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_VISIBLE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_FRAME    = 3'd5;

   localparam int unsigned TICKS_W = 9;
   localparam int unsigned LINE_W  = 8;
   localparam int unsigned SUM_W   = 20;
   localparam int unsigned CSR_DATA_W = TICKS_W;

   // Timing register reset values.
   localparam logic [TICKS_W-1:0] RST_OAM_TICKS    = 9'd80;
   localparam logic [TICKS_W-1:0] RST_XFER_TICKS   = 9'd172;
   localparam logic [TICKS_W-1:0] RST_HBLANK_TICKS = 9'd204;
   localparam logic [TICKS_W-1:0] RST_VBLANK_TICKS = 9'd456;
   localparam logic [LINE_W-1:0]  RST_LAST_VISIBLE = 8'd143;
   localparam logic [LINE_W-1:0]  RST_LAST_FRAME   = 8'd153;

   localparam int unsigned REQ_TDATA_W = 16;
   localparam int unsigned REQ_TUSER_W = 4;
   localparam int unsigned RSP_TDATA_W = 24;

   typedef struct packed {
      logic [TICKS_W-1:0] oam_search_ticks;
      logic [TICKS_W-1:0] transfer_ticks;
      logic [TICKS_W-1:0] hblank_ticks;
      logic [TICKS_W-1:0] vblank_line_ticks;
      logic [LINE_W-1:0]  last_visible_line;
      logic [LINE_W-1:0]  last_frame_line;
   } cfg_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] reg_select;
      logic [7:0] write_data;
      logic [7:0] cycles;
   } item_type;

   typedef struct packed {
      logic [7:0]         control_reg;
      logic [7:0]         status_reg;
      logic [LINE_W-1:0]  line_counter;
      logic [LINE_W-1:0]  compare_line;
      logic [SUM_W-1:0]   cycle_sum;
      logic [TICKS_W-1:0] action_time;
      logic               frame_start;
   } state_type;

   typedef struct packed {
      logic              vblank_irq;
      logic              stat_irq;
      logic [7:0]        read_data;
      logic [1:0]        mode;
      logic [LINE_W-1:0] line;
   } result_type;

endpackage

[rtl/lmts_cfg_regs.sv]
// ----------------------------------------------------------------------------
// LCD mode timing sequencer timing registers
// Holds the six timing registers written through the configuration port.
// ----------------------------------------------------------------------------
module lmts_cfg_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lmts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lmts_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output lmts_pkg::cfg_type               cfg
);
   import lmts_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OAM_TICKS:    cfg_in.oam_search_ticks  = csr_wdata;
            CSR_XFER_TICKS:   cfg_in.transfer_ticks    = csr_wdata;
            CSR_HBLANK_TICKS: cfg_in.hblank_ticks      = csr_wdata;
            CSR_VBLANK_TICKS: cfg_in.vblank_line_ticks = csr_wdata;
            CSR_LAST_VISIBLE: cfg_in.last_visible_line = csr_wdata[LINE_W-1:0];
            CSR_LAST_FRAME:   cfg_in.last_frame_line   = csr_wdata[LINE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.oam_search_ticks  <= RST_OAM_TICKS;
         cfg_ff.transfer_ticks    <= RST_XFER_TICKS;
         cfg_ff.hblank_ticks      <= RST_HBLANK_TICKS;
         cfg_ff.vblank_line_ticks <= RST_VBLANK_TICKS;
         cfg_ff.last_visible_line <= RST_LAST_VISIBLE;
         cfg_ff.last_frame_line   <= RST_LAST_FRAME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/lmts_step.sv]
// ----------------------------------------------------------------------------
// LCD mode timing sequencer step logic
// Computes the next sequencer state and the result for one item.
// ----------------------------------------------------------------------------
module lmts_step (
   input  lmts_pkg::cfg_type    cfg,
   input  lmts_pkg::state_type  cur,
   input  lmts_pkg::item_type   item,
   output lmts_pkg::state_type  nxt,
   output lmts_pkg::result_type res
);
   import lmts_pkg::*;

   always_comb begin
      logic [SUM_W:0]     sum_wide;
      logic [SUM_W-1:0]   sum_sat;
      logic [1:0]         prev_mode;
      logic [1:0]         new_mode;
      logic               wrap;
      logic               was_on;
      logic               now_on;
      logic [LINE_W-1:0]  line_inc;

      nxt       = cur;
      res       = '0;
      sum_wide  = {1'b0, cur.cycle_sum} + {{(SUM_W+1-8){1'b0}}, item.cycles};
      sum_sat   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      prev_mode = cur.status_reg[1:0];
      line_inc  = cur.line_counter + 8'd1;
      wrap      = 1'b0;
      was_on    = cur.control_reg[CTRL_ENABLE_BIT];
      now_on    = item.write_data[CTRL_ENABLE_BIT];

      // Mode sequence: OAM search, transfer, hblank, then either the next
      // line's OAM search or vblank after the last visible line.
      case (prev_mode)
         MODE_OAM:    new_mode = MODE_XFER;
         MODE_XFER:   new_mode = MODE_HBLANK;
         MODE_HBLANK: new_mode = (cur.line_counter == cfg.last_visible_line) ?
                                 MODE_VBLANK : MODE_OAM;
         default: begin
            wrap     = (cur.line_counter == cfg.last_frame_line);
            new_mode = wrap ? MODE_OAM : MODE_VBLANK;
         end
      endcase

      case (item.operation)
         OP_TICK: begin
            if (was_on) begin
               nxt.cycle_sum = sum_sat;
               if (sum_sat >= {{(SUM_W-TICKS_W){1'b0}}, cur.action_time}) begin
                  nxt.cycle_sum = sum_sat - {{(SUM_W-TICKS_W){1'b0}}, cur.action_time};
                  nxt.status_reg[1:0] = new_mode;
                  case (new_mode)
                     MODE_OAM: begin
                        nxt.line_counter = (cur.frame_start || wrap) ? '0 : line_inc;
                        nxt.frame_start  = 1'b0;
                        nxt.action_time  = cfg.oam_search_ticks;
                     end
                     MODE_XFER:   nxt.action_time = cfg.transfer_ticks;
                     MODE_HBLANK: nxt.action_time = cfg.hblank_ticks;
                     default: begin
                        nxt.action_time  = cfg.vblank_line_ticks;
                        nxt.line_counter = line_inc;
                     end
                  endcase
                  if (prev_mode != new_mode) begin
                     case (new_mode)
                        MODE_OAM:    res.stat_irq = cur.status_reg[STAT_OAM_IE];
                        MODE_HBLANK: res.stat_irq = cur.status_reg[STAT_HBLANK_IE];
                        MODE_VBLANK: begin
                           res.stat_irq   = cur.status_reg[STAT_VBLANK_IE];
                           res.vblank_irq = 1'b1;
                        end
                        default:     res.stat_irq = 1'b0;
                     endcase
                  end
                  // The compare match is checked on every entry to OAM search
                  // and leaves a sticky flag in status.
                  if (new_mode == MODE_OAM && nxt.line_counter == cur.compare_line) begin
                     nxt.status_reg[STAT_MATCH_BIT] = 1'b1;
                     if (cur.status_reg[STAT_MATCH_IE]) begin
                        res.stat_irq = 1'b1;
                     end
                  end
               end
            end
         end
         OP_WRITE: begin
            case (item.reg_select)
               SEL_CONTROL: begin
                  nxt.control_reg = item.write_data;
                  if (was_on != now_on) begin
                     nxt.line_counter    = '0;
                     nxt.cycle_sum       = '0;
                     nxt.status_reg[1:0] = MODE_HBLANK;
                     if (now_on) begin
                        nxt.action_time = '0;
                        nxt.frame_start = 1'b1;
                     end
                  end
               end
               SEL_STATUS: nxt.status_reg   = item.write_data;
               SEL_LINE:   nxt.line_counter = item.write_data;
               default:    nxt.compare_line = item.write_data;
            endcase
         end
         OP_READ: begin
            case (item.reg_select)
               SEL_CONTROL: res.read_data = cur.control_reg;
               SEL_STATUS:  res.read_data = cur.status_reg;
               SEL_LINE:    res.read_data = cur.line_counter;
               default:     res.read_data = cur.compare_line;
            endcase
         end
         default: nxt = cur;
      endcase

      res.mode = nxt.status_reg[1:0];
      res.line = nxt.line_counter;
   end

endmodule

[rtl/lcd_mode_timing_sequencer.sv]
// ----------------------------------------------------------------------------
// LCD mode timing sequencer
// Tracks display mode and line timing from tick reports and serves bus
// accesses to the control, status, line and compare registers.
// ----------------------------------------------------------------------------
// The sequencer takes one item per clock cycle while the result side is not
// stalled and returns exactly one result per item. An item first lands in an
// input register; the step logic (one 21-bit saturating add, one compare and
// subtract against the pending action time, and a small mode update) works on
// it there, and once the output register is empty or being emptied the result
// goes into the output register while the sequencer state is updated in the
// same edge. The input stays open while a finished result waits, so a full
// item can sit in each register; throughput is one item per cycle whenever
// the result side takes every transfer. Timing registers are written through
// the csr_ port at any edge where csr_we is high and should only change while
// no item is in flight.
// ----------------------------------------------------------------------------
module lcd_mode_timing_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata: write_data [7:0], cycles [15:8]
   input  logic [lmts_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: operation [1:0], reg_select [3:2]
   input  logic [lmts_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata: vblank_irq [0], stat_irq [1], read_data [9:2], mode [11:10],
   // line [19:12], zero [23:20]
   output logic [lmts_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // Configuration port.
   input  logic                              csr_we,
   input  logic [lmts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lmts_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lmts_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_in;
   logic       item_valid_ff;
   logic       item_valid_in;
   state_type  state_ff;
   state_type  state_nxt;
   state_type  state_in;
   result_type step_res;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       advance;
   logic       req_take;

   lmts_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lmts_step u_step (
      .cfg  (cfg),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_nxt),
      .res  (step_res)
   );

   // The held item moves on when the output register is empty or being
   // emptied in this cycle; the input register refills in the same cycle.
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !advance;
      if (req_take) begin
         item_in.operation  = req_tuser[1:0];
         item_in.reg_select = req_tuser[3:2];
         item_in.write_data = req_tdata[7:0];
         item_in.cycles     = req_tdata[15:8];
         item_valid_in      = 1'b1;
      end
   end

   always_comb begin
      state_in     = advance ? state_nxt : state_ff;
      rsp_in       = advance ? step_res : rsp_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.line, rsp_ff.mode, rsp_ff.read_data,
                        rsp_ff.stat_irq, rsp_ff.vblank_irq};

endmodule

[tb/tb_lcd_mode_timing_sequencer.sv]
// ----------------------------------------------------------------------------
// LCD mode timing sequencer testbench
// Drives tick reports and register accesses into the sequencer. A shadow
// copy of the display timing state predicts the result of every accepted
// transfer, and each returned result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_lcd_mode_timing_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import lmts_pkg::*;

   // The operation code the block ignores.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Run length guard for the whole run.
   localparam int unsigned CYCLE_LIMIT = 100000;

   // Length of the one long stall on the result side.
   localparam int unsigned LONG_HOLD = 300;

   // Cycles to wait after the last result.
   localparam int unsigned DRAIN_CYCLES = 16;

   // Number of full ticks used to build up a large cycle sum.
   localparam int unsigned ACCUM_TICKS = 40;

   localparam logic [SUM_W-1:0] SUM_CEILING = '1;

   // -------------------------------------------------------------------------
   // Clock, reset and the block's inputs, all known from time zero.
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   lcd_mode_timing_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Shadow state of the sequencer. It starts at the reset values and only
   // moves when a transfer is accepted or a timing register is written.
   // -------------------------------------------------------------------------
   cfg_type            shadow_timing = {RST_OAM_TICKS, RST_XFER_TICKS, RST_HBLANK_TICKS,
                                        RST_VBLANK_TICKS, RST_LAST_VISIBLE, RST_LAST_FRAME};
   logic [7:0]         shadow_control = '0;
   logic [7:0]         shadow_status  = '0;
   logic [LINE_W-1:0]  shadow_line    = '0;
   logic [LINE_W-1:0]  shadow_compare = '0;
   logic [SUM_W-1:0]   shadow_sum     = '0;
   logic [TICKS_W-1:0] shadow_due     = '0;
   logic               shadow_restart = 1'b0;

   // Items waiting to be offered, and results owed by the block.
   item_type   pending_req[$];
   result_type expected_rsp[$];
   item_type   on_bus;

   // Idling controls, set per phase by the stimulus process.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // A change of hold_req asks the receiver for one long stall.
   int unsigned hold_req  = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;

   // Works out the result of one accepted item and updates the shadow state.
   task automatic lcd_step(input item_type it, output result_type res);
      logic [SUM_W:0] sum_wide;
      logic [1:0]     prev_mode;
      logic           was_on;
      logic           now_on;
      res = '0;
      case (it.operation)
         OP_TICK: begin
            if (shadow_control[CTRL_ENABLE_BIT]) begin
               // The sum saturates instead of wrapping.
               sum_wide = shadow_sum + it.cycles;
               if (sum_wide > {1'b0, SUM_CEILING}) begin
                  sum_wide = {1'b0, SUM_CEILING};
               end
               shadow_sum = sum_wide[SUM_W-1:0];
               if (shadow_sum >= shadow_due) begin
                  prev_mode = shadow_status[1:0];
                  shadow_sum = shadow_sum - shadow_due;
                  // Pick the next mode.
                  case (shadow_status[1:0])
                     MODE_OAM:    shadow_status[1:0] = MODE_XFER;
                     MODE_XFER:   shadow_status[1:0] = MODE_HBLANK;
                     MODE_HBLANK: begin
                        shadow_status[1:0] = (shadow_line == shadow_timing.last_visible_line)
                                             ? MODE_VBLANK : MODE_OAM;
                     end
                     default: begin
                        if (shadow_line == shadow_timing.last_frame_line) begin
                           shadow_restart = 1'b1;
                           shadow_status[1:0] = MODE_OAM;
                        end
                     end
                  endcase
                  // Load the time of the next action and move the line.
                  case (shadow_status[1:0])
                     MODE_OAM: begin
                        shadow_line = shadow_restart ? 8'd0 : shadow_line + 8'd1;
                        shadow_restart = 1'b0;
                        shadow_due = shadow_timing.oam_search_ticks;
                     end
                     MODE_XFER:   shadow_due = shadow_timing.transfer_ticks;
                     MODE_HBLANK: shadow_due = shadow_timing.hblank_ticks;
                     default: begin
                        shadow_due = shadow_timing.vblank_line_ticks;
                        shadow_line = shadow_line + 8'd1;
                     end
                  endcase
                  if (prev_mode != shadow_status[1:0]) begin
                     if (shadow_status[1:0] == MODE_OAM && shadow_status[STAT_OAM_IE])
                        res.stat_irq = 1'b1;
                     if (shadow_status[1:0] == MODE_HBLANK && shadow_status[STAT_HBLANK_IE])
                        res.stat_irq = 1'b1;
                     if (shadow_status[1:0] == MODE_VBLANK && shadow_status[STAT_VBLANK_IE])
                        res.stat_irq = 1'b1;
                     if (shadow_status[1:0] == MODE_VBLANK)
                        res.vblank_irq = 1'b1;
                  end
                  // The match flag is sticky; it is only cleared by a status write.
                  if (shadow_status[1:0] == MODE_OAM && shadow_line == shadow_compare) begin
                     shadow_status[STAT_MATCH_BIT] = 1'b1;
                     if (shadow_status[STAT_MATCH_IE]) res.stat_irq = 1'b1;
                  end
               end
            end
         end
         OP_WRITE: begin
            case (it.reg_select)
               SEL_CONTROL: begin
                  was_on = shadow_control[CTRL_ENABLE_BIT];
                  now_on = it.write_data[CTRL_ENABLE_BIT];
                  shadow_control = it.write_data;
                  if (!was_on && now_on) begin
                     shadow_line = '0;
                     shadow_sum = '0;
                     shadow_due = '0;
                     shadow_status[1:0] = MODE_HBLANK;
                     shadow_restart = 1'b1;
                  end else if (was_on && !now_on) begin
                     shadow_line = '0;
                     shadow_sum = '0;
                     shadow_status[1:0] = MODE_HBLANK;
                  end
               end
               SEL_STATUS: shadow_status = it.write_data;
               SEL_LINE:   shadow_line = it.write_data;
               default:    shadow_compare = it.write_data;
            endcase
         end
         OP_READ: begin
            case (it.reg_select)
               SEL_CONTROL: res.read_data = shadow_control;
               SEL_STATUS:  res.read_data = shadow_status;
               SEL_LINE:    res.read_data = shadow_line;
               default:     res.read_data = shadow_compare;
            endcase
         end
         default: ;
      endcase
      res.mode = shadow_status[1:0];
      res.line = shadow_line;
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // -------------------------------------------------------------------------
   // Driver. A transfer seen at this edge is handed to the shadow model; then
   // the next item from the pending queue is offered, unless this cycle is
   // chosen to be idle. tvalid is written at most once per edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type res;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            lcd_step(on_bus, res);
            expected_rsp.push_back(res);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = pending_req.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {on_bus.cycles, on_bus.write_data};
               req_tuser  <= {on_bus.reg_select, on_bus.operation};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver backpressure. A new hold request starts one long stall that is
   // counted down here; otherwise tready follows the phase's stall rate.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen  <= hold_req;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor. Every result transfer is compared with the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $error("result transfer with no prediction pending: tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("vblank_irq", want.vblank_irq, rsp_tdata[0]);
            check_field("stat_irq", want.stat_irq, rsp_tdata[1]);
            check_field("read_data", want.read_data, rsp_tdata[9:2]);
            check_field("mode", want.mode, rsp_tdata[11:10]);
            check_field("line", want.line, rsp_tdata[19:12]);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_lcd_mode_timing_sequencer NOT OK");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------
   task automatic push_item(input logic [1:0] op, input logic [1:0] sel,
                            input logic [7:0] wdata, input logic [7:0] cyc);
      item_type it;
      it.operation  = op;
      it.reg_select = sel;
      it.write_data = wdata;
      it.cycles     = cyc;
      pending_req.push_back(it);
   endtask

   // Blocks until nothing is queued, offered or owed by the block.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_req.size() != 0 || req_tvalid || expected_rsp.size() != 0);
   endtask

   // Writes one timing register; the shadow copy follows at the same edge.
   task automatic write_timing(input logic [CSR_INDEX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_OAM_TICKS:    shadow_timing.oam_search_ticks  = value;
         CSR_XFER_TICKS:   shadow_timing.transfer_ticks    = value;
         CSR_HBLANK_TICKS: shadow_timing.hblank_ticks      = value;
         CSR_VBLANK_TICKS: shadow_timing.vblank_line_ticks = value;
         CSR_LAST_VISIBLE: shadow_timing.last_visible_line = value[LINE_W-1:0];
         CSR_LAST_FRAME:   shadow_timing.last_frame_line   = value[LINE_W-1:0];
         default: ;
      endcase
   endtask

   // Short modes and a handful of lines, so that whole frames go by quickly.
   function automatic cfg_type small_timing();
      cfg_type c;
      c.oam_search_ticks  = 9'($urandom_range(1, 40));
      c.transfer_ticks    = 9'($urandom_range(1, 40));
      c.hblank_ticks      = 9'($urandom_range(1, 40));
      c.vblank_line_ticks = 9'($urandom_range(1, 40));
      c.last_visible_line = 8'($urandom_range(0, 6));
      c.last_frame_line   = 8'(c.last_visible_line + $urandom_range(1, 4));
      return c;
   endfunction

   // Mostly ticks, so the frame keeps moving, with reads, writes and a few
   // ignored operations in between. Compare and line values stay near the
   // lines the frame actually uses so that matches happen often.
   function automatic item_type random_item();
      item_type    it;
      int unsigned pick;
      int unsigned span;
      span = shadow_timing.last_frame_line;
      if (shadow_timing.last_visible_line > span) span = shadow_timing.last_visible_line;
      span = (span + 2 > 255) ? 255 : span + 2;
      pick = $urandom_range(99);
      it.reg_select = 2'($urandom_range(3));
      it.write_data = 8'($urandom_range(255));
      it.cycles     = ($urandom_range(99) < 80) ? 8'($urandom_range(60))
                                                : 8'($urandom_range(255));
      if (pick < 68) begin
         it.operation = OP_TICK;
      end else if (pick < 80) begin
         it.operation = OP_READ;
      end else if (pick < 88) begin
         it.operation  = OP_WRITE;
         it.reg_select = ($urandom_range(1) != 0) ? SEL_COMPARE : SEL_LINE;
         if ($urandom_range(9) != 0) it.write_data = 8'($urandom_range(span));
      end else if (pick < 93) begin
         it.operation  = OP_WRITE;
         it.reg_select = SEL_STATUS;
      end else if (pick < 97) begin
         // Control writes leave the display on most of the time.
         it.operation  = OP_WRITE;
         it.reg_select = SEL_CONTROL;
         if ($urandom_range(99) < 75) it.write_data[CTRL_ENABLE_BIT] = 1'b1;
      end else begin
         it.operation = OP_UNUSED;
      end
      return it;
   endfunction

   task automatic queue_random(input int unsigned count);
      // Each batch opens with the display switched on.
      push_item(OP_WRITE, SEL_CONTROL, 8'h80 | 8'($urandom_range(127)),
                8'($urandom_range(255)));
      repeat (count - 1) pending_req.push_back(random_item());
   endtask

   // One phase: set the idling, load the timing, then two batches with a
   // full drain between them, which is the sender's pause for all results.
   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                            input cfg_type timing, input int unsigned count,
                            input bit long_hold);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      write_timing(CSR_OAM_TICKS, timing.oam_search_ticks);
      write_timing(CSR_XFER_TICKS, timing.transfer_ticks);
      write_timing(CSR_HBLANK_TICKS, timing.hblank_ticks);
      write_timing(CSR_VBLANK_TICKS, timing.vblank_line_ticks);
      write_timing(CSR_LAST_VISIBLE, {1'b0, timing.last_visible_line});
      write_timing(CSR_LAST_FRAME, {1'b0, timing.last_frame_line});
      @(negedge clock);
      queue_random(count / 2);
      // The long stall lets the sequencer fill up and hold off its input
      // while the driver keeps offering items.
      if (long_hold) hold_req++;
      wait_idle();
      queue_random(count - count / 2);
      wait_idle();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      cfg_type timing;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset timing. A tick while the display is off
      // does nothing, and every register reads back its reset value.
      push_item(OP_TICK, SEL_CONTROL, 8'hA5, 8'd255);
      push_item(OP_READ, SEL_CONTROL, 8'h00, 8'h00);
      push_item(OP_READ, SEL_STATUS, 8'h00, 8'h00);
      push_item(OP_READ, SEL_LINE, 8'h00, 8'h00);
      push_item(OP_READ, SEL_COMPARE, 8'h00, 8'h00);
      // Enable every status interrupt, then switch the display on. The
      // action time is zero after the rising edge, so a zero-cycle tick
      // enters OAM search at line 0 and hits the compare match there.
      push_item(OP_WRITE, SEL_STATUS, 8'h78, 8'h00);
      push_item(OP_WRITE, SEL_CONTROL, 8'h80, 8'h00);
      push_item(OP_TICK, SEL_STATUS, 8'h00, 8'd0);
      // One cycle short of the OAM search time, then the cycle that ends it.
      push_item(OP_TICK, SEL_LINE, 8'hFF, 8'd79);
      push_item(OP_TICK, SEL_COMPARE, 8'h00, 8'd1);
      push_item(OP_TICK, SEL_CONTROL, 8'h00, 8'd255);
      push_item(OP_TICK, SEL_CONTROL, 8'h00, 8'd255);
      // Jump to the last visible line and run into vertical blank.
      push_item(OP_WRITE, SEL_LINE, RST_LAST_VISIBLE, 8'h00);
      push_item(OP_TICK, SEL_CONTROL, 8'h00, 8'd255);
      push_item(OP_TICK, SEL_CONTROL, 8'h00, 8'd255);
      push_item(OP_TICK, SEL_CONTROL, 8'h00, 8'd255);
      // Jump to the last frame line so the frame restarts at line 0.
      push_item(OP_WRITE, SEL_LINE, RST_LAST_FRAME, 8'h00);
      push_item(OP_TICK, SEL_CONTROL, 8'h00, 8'd255);
      push_item(OP_TICK, SEL_CONTROL, 8'h00, 8'd255);
      // A status write stores all bits, mode and match flag included.
      push_item(OP_WRITE, SEL_STATUS, 8'hFF, 8'h00);
      push_item(OP_READ, SEL_STATUS, 8'h00, 8'h00);
      // The unused operation changes nothing.
      push_item(OP_UNUSED, SEL_COMPARE, 8'hFF, 8'hFF);
      // Falling edge, then a rising edge with every other control bit set.
      push_item(OP_WRITE, SEL_CONTROL, 8'h7F, 8'h00);
      push_item(OP_READ, SEL_LINE, 8'h00, 8'h00);
      push_item(OP_WRITE, SEL_CONTROL, 8'hFF, 8'h00);
      wait_idle();

      // No idling, short frames, and the one long receiver stall.
      run_phase(0, 0, small_timing(), 200, 1'b1);

      // Shortest timing: every nonzero tick fires, and with both last lines
      // at 0 vertical blank counts through the line wrap before restarting.
      timing = '0;
      timing.oam_search_ticks  = 9'd1;
      timing.transfer_ticks    = 9'd1;
      timing.hblank_ticks      = 9'd1;
      timing.vblank_line_ticks = 9'd1;
      run_phase(88, 0, timing, 200, 1'b0);

      // Longest timing and the highest last lines.
      timing = '1;
      run_phase(0, 88, timing, 150, 1'b0);

      run_phase(21, 21, small_timing(), 300, 1'b0);

      timing = {RST_OAM_TICKS, RST_XFER_TICKS, RST_HBLANK_TICKS,
                RST_VBLANK_TICKS, RST_LAST_VISIBLE, RST_LAST_FRAME};
      run_phase(21, 21, timing, 150, 1'b0);

      run_phase(0, 0, small_timing(), 170, 1'b0);

      // Large cycle sum: with every action time set to 1, a full tick fires
      // one action only and leaves the rest of its count behind, so the sum
      // climbs far above any action time. A falling edge then clears it again.
      timing = '0;
      timing.oam_search_ticks  = 9'd1;
      timing.transfer_ticks    = 9'd1;
      timing.hblank_ticks      = 9'd1;
      timing.vblank_line_ticks = 9'd1;
      timing.last_visible_line = 8'd255;
      timing.last_frame_line   = 8'd255;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_timing(CSR_OAM_TICKS, timing.oam_search_ticks);
      write_timing(CSR_XFER_TICKS, timing.transfer_ticks);
      write_timing(CSR_HBLANK_TICKS, timing.hblank_ticks);
      write_timing(CSR_VBLANK_TICKS, timing.vblank_line_ticks);
      write_timing(CSR_LAST_VISIBLE, {1'b0, timing.last_visible_line});
      write_timing(CSR_LAST_FRAME, {1'b0, timing.last_frame_line});
      @(negedge clock);
      push_item(OP_WRITE, SEL_CONTROL, 8'h00, 8'h00);
      push_item(OP_WRITE, SEL_CONTROL, 8'h80, 8'h00);
      repeat (ACCUM_TICKS) push_item(OP_TICK, SEL_CONTROL, 8'h00, 8'd255);
      push_item(OP_READ, SEL_STATUS, 8'h00, 8'h00);
      push_item(OP_WRITE, SEL_CONTROL, 8'h00, 8'h00);
      push_item(OP_WRITE, SEL_CONTROL, 8'h80, 8'h00);
      push_item(OP_TICK, SEL_CONTROL, 8'h00, 8'd0);
      push_item(OP_READ, SEL_LINE, 8'h00, 8'h00);
      wait_idle();

      // Give any stray result time to show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_lcd_mode_timing_sequencer OK");
      end else begin
         $display("tb_lcd_mode_timing_sequencer NOT OK");
      end
      $finish;
   end

endmodule

[lcd_mode_timing_sequencer.f]
rtl/lmts_pkg.sv
rtl/lmts_cfg_regs.sv
rtl/lmts_step.sv
rtl/lcd_mode_timing_sequencer.sv
tb/tb_lcd_mode_timing_sequencer.sv
